// File: rtl/mtfc_pkg.sv
// Package for the move-to-front codec: mode codes, controller states and
// the control group that the top level hands to every table cell.
// Has no dependencies.
`timescale 1ns / 1ps

package mtfc_pkg;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mtfc_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MOVE
  } mtfc_state_e;

  // Fan-in of one level of the result tree, as a power of two.
  localparam int unsigned FANIN_BITS = 4;

  typedef struct packed {
    logic restart;  // load the identity order
    logic move;     // take the neighbor's entry when at or before the position
  } mtfc_cell_ctrl_t;

endpackage

// File: rtl/move_to_front_codec_unit.sv
// Top level of the move-to-front codec: controller, row of table cells and
// result tree. Depends on mtfc_pkg, mtfc_cell and mtfc_or_tree.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    symbol_in_i, restart_i
//   output    out        out_valid_o / out_stall_i  symbol_out_o
//   config    in         cfg_we_i                   cfg_wdata_i (mode)
//
// An item is accepted in ST_IDLE, passes the levels of the registered result tree
// in ST_REDUCE and is moved in ST_MOVE; no new item is accepted before the move.
// The move waits while a finished result is still held on the output.
// Reset loads the identity order into the cells at once and selects encoding.
// A restart flag loads the identity order in the cycle of the transfer.
`timescale 1ns / 1ps

module move_to_front_codec_unit #(
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_in_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] symbol_out_o
);
  import mtfc_pkg::*;

  localparam int unsigned NumCells = 1 << SYMBOL_BITS;
  localparam int unsigned TreeLat  = (SYMBOL_BITS + FANIN_BITS - 1) / FANIN_BITS;
  localparam int unsigned CntW     = (TreeLat > 1) ? $clog2(TreeLat) : 1;

  mtfc_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  mtfc_mode_e      mode_q;
  logic            out_valid_q;
  logic [7:0]      sym_out_q;
  logic [SYMBOL_BITS-1:0] key_q;
  logic [SYMBOL_BITS-1:0] key_d;

  logic                   in_xfer;
  logic                   out_xfer;
  logic                   move_go;
  mtfc_cell_ctrl_t        cell_ctrl;
  logic [SYMBOL_BITS-1:0] root;
  logic [SYMBOL_BITS-1:0] front_sym;
  logic [SYMBOL_BITS-1:0] move_pos;
  logic [7:0]             result8;

  logic [SYMBOL_BITS-1:0]          cell_entry [NumCells];
  logic [NumCells-1:0]             cell_hit;
  logic [NumCells*SYMBOL_BITS-1:0] contrib_flat;

  // Fit the 8-bit ports to the table width.
  if (SYMBOL_BITS <= 8) begin : g_narrow_in
    assign key_d = symbol_in_i[SYMBOL_BITS-1:0];
  end else begin : g_wide_in
    assign key_d = {{(SYMBOL_BITS-8){1'b0}}, symbol_in_i};
  end

  if (SYMBOL_BITS >= 8) begin : g_wide_out
    assign result8 = root[7:0];
  end else begin : g_narrow_out
    assign result8 = {{(8-SYMBOL_BITS){1'b0}}, root};
  end

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;

  always_comb begin
    state_d           = state_q;
    cnt_d             = cnt_q;
    in_stall_o        = 1'b1;
    move_go           = 1'b0;
    cell_ctrl.restart = 1'b0;
    cell_ctrl.move    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o        = 1'b0;
        cell_ctrl.restart = in_valid_i && restart_i;
        if (in_valid_i) begin
          state_d = ST_REDUCE;
          cnt_d   = '0;
        end
      end
      ST_REDUCE: begin
        if (cnt_q == CntW'(TreeLat - 1)) begin
          state_d = ST_MOVE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MOVE: begin
        if (!out_valid_q || !out_stall_i) begin
          move_go        = 1'b1;
          cell_ctrl.move = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mode_q      <= MODE_ENCODE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        mode_q <= mtfc_mode_e'(cfg_wdata_i);
      end
      if (move_go) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      key_q <= key_d;
    end
    if (move_go) begin
      sym_out_q <= result8;
    end
  end

  // The tree root is the found position when encoding and the symbol when decoding.
  assign front_sym = (mode_q == MODE_DECODE) ? root : key_q;
  assign move_pos  = (mode_q == MODE_DECODE) ? key_q : root;

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    logic [SYMBOL_BITS-1:0] prev;
    if (k == 0) begin : g_front
      assign prev = front_sym;
    end else begin : g_chain
      assign prev = cell_entry[k-1];
    end
    mtfc_cell #(
      .SYMBOL_BITS(SYMBOL_BITS),
      .POSITION   (k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .mode_i   (mode_q),
      .key_i    (key_q),
      .pos_i    (move_pos),
      .prev_i   (prev),
      .entry_o  (cell_entry[k]),
      .hit_o    (cell_hit[k]),
      .contrib_o(contrib_flat[k*SYMBOL_BITS +: SYMBOL_BITS])
    );
  end

  mtfc_or_tree #(
    .WIDTH (SYMBOL_BITS),
    .LEAVES(NumCells)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(contrib_flat),
    .root_o(root)
  );

  assign out_valid_o  = out_valid_q;
  assign symbol_out_o = sym_out_q;

  // The table is always a permutation, so exactly one cell matches the key.
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE) |-> $onehot(cell_hit))
    else $error("table cells do not hold exactly one match for the key");

  a_front_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move_go |=> (cell_entry[0] == $past(front_sym)))
    else $error("moved symbol did not land in the front cell");

  a_result_from_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_MOVE))
    else $error("result appeared without a move");

  a_move_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE && out_valid_q && out_stall_i) |=> (state_q == ST_MOVE))
    else $error("move overran a result that was not yet transferred");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (in_stall_o && state_q == ST_REDUCE))
    else $error("controller did not start working on the accepted item");

endmodule

// File: rtl/mtfc_cell.sv
// One table cell: holds the entry at a fixed position, compares the entry
// (encoding) or the position (decoding) against the current key and shifts
// in its neighbor's entry on a move. Depends on mtfc_pkg.
`timescale 1ns / 1ps

module mtfc_cell #(
  parameter int unsigned SYMBOL_BITS = 8,
  parameter int unsigned POSITION    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mtfc_pkg::mtfc_cell_ctrl_t    ctrl_i,
  input  mtfc_pkg::mtfc_mode_e         mode_i,
  input  logic [SYMBOL_BITS-1:0]       key_i,
  input  logic [SYMBOL_BITS-1:0]       pos_i,
  input  logic [SYMBOL_BITS-1:0]       prev_i,
  output logic [SYMBOL_BITS-1:0]       entry_o,
  output logic                         hit_o,
  output logic [SYMBOL_BITS-1:0]       contrib_o
);
  import mtfc_pkg::*;

  localparam logic [SYMBOL_BITS-1:0] PosV = SYMBOL_BITS'(POSITION);

  logic [SYMBOL_BITS-1:0] entry_q;
  logic [SYMBOL_BITS-1:0] entry_d;

  // Encoding looks for the cell holding the key; decoding addresses the cell.
  always_comb begin
    if (mode_i == MODE_DECODE) begin
      hit_o     = (PosV == key_i);
      contrib_o = hit_o ? entry_q : '0;
    end else begin
      hit_o     = (entry_q == key_i);
      contrib_o = hit_o ? PosV : '0;
    end
  end

  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.restart) begin
      entry_d = PosV;
    end else if (ctrl_i.move && (PosV <= pos_i)) begin
      entry_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= PosV;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// File: rtl/mtfc_or_tree.sv
// Registered OR tree that merges the cell contributions into one word,
// with a register after each level of sixteen-input ORs.
// Depends on mtfc_pkg.
`timescale 1ns / 1ps

module mtfc_or_tree #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned LEAVES = 256
) (
  input  logic                      clk_i,
  input  logic [LEAVES*WIDTH-1:0]   leaf_i,
  output logic [WIDTH-1:0]          root_o
);
  import mtfc_pkg::*;

  localparam int unsigned LogLeaves = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int unsigned Levels    = (LogLeaves + FANIN_BITS - 1) / FANIN_BITS;
  localparam int unsigned Fanin     = 1 << FANIN_BITS;
  localparam int unsigned Slots     = 1 << (FANIN_BITS * Levels);

  logic [WIDTH-1:0] base [Slots];
  logic [WIDTH-1:0] tree_q [Levels][Slots];

  always_comb begin
    for (int j = 0; j < Slots; j++) begin
      base[j] = (j < LEAVES) ? leaf_i[(j % LEAVES)*WIDTH +: WIDTH] : '0;
    end
  end

  // Slots that no parent reads fold to zero and are trimmed by synthesis.
  always_ff @(posedge clk_i) begin
    logic [WIDTH-1:0] acc;
    int               idx;
    for (int l = 0; l < Levels; l++) begin
      for (int j = 0; j < Slots; j++) begin
        acc = '0;
        for (int c = 0; c < Fanin; c++) begin
          idx = j * Fanin + c;
          if (idx < Slots) begin
            acc = acc | ((l == 0) ? base[idx] : tree_q[(l == 0) ? 0 : l-1][idx]);
          end
        end
        tree_q[l][j] <= acc;
      end
    end
  end

  assign root_o = tree_q[Levels-1][0];

endmodule

// File: verif/tb_move_to_front_codec_unit.sv
// Self-checking testbench for move_to_front_codec_unit: encodes and decodes
// symbol streams under random idling and back-pressure against its own table.
// Depends on mtfc_pkg and the move_to_front_codec_unit RTL.
`timescale 1ns / 1ps

module tb_move_to_front_codec_unit;
  import mtfc_pkg::*;

  localparam int unsigned TABLE_SIZE  = 256;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned SETTLE_CYC  = 8;
  localparam int unsigned HOLD_CYC    = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_wdata_i  = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] symbol_in_i  = 8'd0;
  logic       restart_i    = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] symbol_out_o;

  // Predictor state: the symbol order and the coding mode.
  logic [7:0] order_tbl [TABLE_SIZE];
  mtfc_mode_e coder_mode;
  logic [7:0] expected_symbols [$];
  logic [7:0] palette [8];

  int unsigned cycle_cnt     = 0;
  int unsigned mismatch_cnt  = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  bit          send_idle_on  = 1'b1;
  bit          recv_idle_on  = 1'b1;

  move_to_front_codec_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .symbol_in_i (symbol_in_i),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .symbol_out_o(symbol_out_o)
  );

  always #5 clk_i = ~clk_i;

  // Codes one item against the local table and moves its symbol to the front.
  function automatic logic [7:0] predict_code(input logic [7:0] val, input logic rst);
    int unsigned pos;
    logic [7:0]  sym;
    pos = 0;
    if (rst) begin
      for (int k = 0; k < TABLE_SIZE; k++) order_tbl[k] = 8'(k);
    end
    if (coder_mode == MODE_ENCODE) begin
      for (int k = TABLE_SIZE - 1; k >= 0; k--) begin
        if (order_tbl[k] == val) pos = k;
      end
    end else begin
      pos = val;
    end
    sym = order_tbl[pos];
    for (int k = pos; k > 0; k--) order_tbl[k] = order_tbl[k - 1];
    order_tbl[0] = sym;
    return (coder_mode == MODE_ENCODE) ? 8'(pos) : sym;
  endfunction

  // Offers one item and returns at the edge of its transfer.
  task automatic send_item(input logic [7:0] sym, input logic rst);
    while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    symbol_in_i <= sym;
    restart_i   <= rst;
    do @(posedge clk_i); while (in_stall_o);
    expected_symbols.push_back(predict_code(sym, rst));
  endtask

  // Stops offering and waits until every result is in and the block has settled.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_mode(input mtfc_mode_e m);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    coder_mode  = m;
  endtask

  task automatic new_palette();
    foreach (palette[i]) palette[i] = 8'($urandom_range(0, 255));
  endtask

  // Random items with locality, so that both short and long moves occur.
  task automatic send_random(input int unsigned n);
    logic [7:0]  sym;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (coder_mode == MODE_ENCODE) begin
        if (pick < 6) sym = palette[$urandom_range(0, 7)];
        else if (pick < 9) sym = 8'($urandom_range(0, 255));
        else sym = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        if (pick < 6) sym = 8'($urandom_range(0, 3));
        else if (pick < 9) sym = 8'($urandom_range(0, 255));
        else sym = 8'hFF;
      end
      send_item(sym, $urandom_range(0, 99) < 3);
    end
  endtask

  // Extremes, a symbol already at the front, and restarts while encoding.
  task automatic test_encode_directed();
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h01, 1'b1);
    send_item(8'h80, 1'b0);
  endtask

  task automatic test_decode_directed();
    set_mode(MODE_DECODE);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h01, 1'b0);
  endtask

  task automatic test_random_encode();
    set_mode(MODE_ENCODE);
    new_palette();
    send_random(250);
  endtask

  task automatic test_random_decode();
    set_mode(MODE_DECODE);
    new_palette();
    send_random(250);
  endtask

  task automatic test_mode_phases();
    for (int p = 0; p < 6; p++) begin
      set_mode(mtfc_mode_e'(p % 2 == 0 ? $urandom_range(0, 1) : p % 3 == 0));
      new_palette();
      send_random(80);
    end
  endtask

  task automatic test_no_idle();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    new_palette();
    send_random(200);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_requests++;
    send_random(40);
  endtask

  task automatic test_sender_pause();
    send_random(20);
    drain();
    send_random(20);
  endtask

  // Receiver: drives the output stall and checks every result transfer.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_move_to_front_codec_unit failed");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_symbols.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("unexpected result transfer: symbol_out=%0d", symbol_out_o);
          mismatch_cnt++;
        end else begin
          if (symbol_out_o !== expected_symbols[0]) begin
            if (mismatch_cnt < 10)
              $display("symbol_out mismatch: expected %0d, actual %0d",
                       expected_symbols[0], symbol_out_o);
            mismatch_cnt++;
          end
          void'(expected_symbols.pop_front());
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= recv_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    for (int k = 0; k < TABLE_SIZE; k++) order_tbl[k] = 8'(k);
    coder_mode = MODE_ENCODE;
    foreach (palette[i]) palette[i] = 8'(i);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_directed();
    test_decode_directed();
    test_random_encode();
    test_random_decode();
    test_mode_phases();
    test_no_idle();
    test_backpressure();
    test_sender_pause();
    drain();

    if (mismatch_cnt == 0 && expected_symbols.size() == 0) begin
      $display("tb_move_to_front_codec_unit passed");
    end else begin
      $display("tb_move_to_front_codec_unit failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/mtfc_pkg.sv
rtl/mtfc_cell.sv
rtl/mtfc_or_tree.sv
rtl/move_to_front_codec_unit.sv
verif/tb_move_to_front_codec_unit.sv
